FILE: design/swk_pkg.sv
package swk_pkg;
  localparam int CordicStagesDef = 16;
  localparam int MaxTab = 24;
  localparam int Frac = 8;
  localparam int ArmW = 12;
  localparam logic [11:0] ArmReset = 12'd300;
  localparam logic signed [31:0] Kinv = 32'sd652032874;
  localparam logic signed [31:0] HalfSqrt2 = 32'sd759250125;
  localparam logic signed [33:0] TurnHalf = 34'sh080000000;
  localparam logic signed [33:0] TurnQuarter = 34'sh040000000;
  localparam int VecW = 36;
  localparam int AngW = 34;
  localparam logic [0:0] RegArm = 1'b0;

  typedef struct packed {
    logic signed [15:0] linear_speed;
    logic signed [15:0] heading;
    logic signed [15:0] yaw_rate;
  } cmd_t;

  typedef struct packed {
    logic [15:0] speed_wheel3;
    logic [15:0] speed_wheel2;
    logic [15:0] speed_wheel1;
    logic [15:0] speed_wheel0;
    logic signed [15:0] angle_wheel3;
    logic signed [15:0] angle_wheel2;
    logic signed [15:0] angle_wheel1;
    logic signed [15:0] angle_wheel0;
  } res_t;

  function automatic logic signed [AngW-1:0] atan_lut(input int i);
    logic signed [AngW-1:0] t;
    case (i)
      0: t = 34'sh020000000;  1: t = 34'sh012E4051E;
      2: t = 34'sh009FB385B;  3: t = 34'sh0051111D4;
      4: t = 34'sh0028B0D43;  5: t = 34'sh00145D7E1;
      6: t = 34'sh000A2F61E;  7: t = 34'sh000517C55;
      8: t = 34'sh00028BE53;  9: t = 34'sh000145F2F;
      10: t = 34'sh0000A2F98; 11: t = 34'sh0000517CC;
      12: t = 34'sh000028BE6; 13: t = 34'sh0000145F3;
      14: t = 34'sh00000A2FA; 15: t = 34'sh00000517D;
      16: t = 34'sh0000028BE; 17: t = 34'sh00000145F;
      18: t = 34'sh000000A30; 19: t = 34'sh000000518;
      20: t = 34'sh00000028C; 21: t = 34'sh000000146;
      22: t = 34'sh0000000A3; 23: t = 34'sh000000051;
      default: t = '0;
    endcase
    return t;
  endfunction
endpackage

FILE: design/swk_rot.sv
module swk_rot #(
  parameter int Stages = swk_pkg::CordicStagesDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  swk_pkg::cmd_t cmd_i,
  input  logic [swk_pkg::ArmW-1:0] arm_i,
  output logic valid_o,
  output logic signed [swk_pkg::VecW-1:0] vx_o,
  output logic signed [swk_pkg::VecW-1:0] vy_o,
  output logic signed [swk_pkg::VecW-1:0] r_o
);
  import swk_pkg::*;
  localparam int N = (Stages > MaxTab) ? MaxTab : Stages;

  logic signed [VecW-1:0] x_q [N+1];
  logic signed [VecW-1:0] y_q [N+1];
  logic signed [AngW-1:0] z_q [N+1];
  logic signed [VecW-1:0] w_q [N+1];
  logic v_q [N+1];
  logic signed [VecW-1:0] x0_d;
  logic signed [AngW-1:0] z0_d;

  always_comb begin
    x0_d = VecW'(cmd_i.linear_speed) <<< Frac;
    z0_d = AngW'(cmd_i.heading) <<< 16;
    if (z0_d > TurnQuarter) begin
      x0_d = -x0_d;
      z0_d = z0_d - TurnHalf;
    end else if (z0_d < -TurnQuarter) begin
      x0_d = -x0_d;
      z0_d = z0_d + TurnHalf;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= x0_d;
      y_q[0] <= '0;
      z_q[0] <= z0_d;
      w_q[0] <= VecW'(cmd_i.yaw_rate) * VecW'($signed({1'b0, arm_i}));
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_st
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else if (en_i) begin
        v_q[i+1] <= v_q[i];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        w_q[i+1] <= w_q[i];
        if (z_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - atan_lut(i);
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + atan_lut(i);
        end
      end
    end
  end

  logic signed [67:0] px_q, py_q, pr_q;
  logic vp_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= 1'b0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      vp_q <= v_q[N];
      valid_o <= vp_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_q <= 68'(x_q[N]) * 68'(Kinv);
      py_q <= 68'(y_q[N]) * 68'(Kinv);
      pr_q <= 68'(w_q[N]) * 68'(HalfSqrt2);
      vx_o <= VecW'((px_q + 68'sd536870912) >>> 30);
      vy_o <= VecW'((py_q + 68'sd536870912) >>> 30);
      r_o  <= VecW'(pr_q >>> 32);
    end
  end
endmodule

FILE: design/swk_vec.sv
module swk_vec #(
  parameter int Stages = swk_pkg::CordicStagesDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  logic signed [swk_pkg::VecW-1:0] x_i,
  input  logic signed [swk_pkg::VecW-1:0] y_i,
  output logic valid_o,
  output logic signed [15:0] ang_o,
  output logic [15:0] spd_o
);
  import swk_pkg::*;
  localparam int N = (Stages > MaxTab) ? MaxTab : Stages;

  logic signed [VecW-1:0] x_q [N+1];
  logic signed [VecW-1:0] y_q [N+1];
  logic signed [AngW-1:0] z_q [N+1];
  logic zero_q [N+1];
  logic v_q [N+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_q[0] <= (x_i == 0) && (y_i == 0);
      if (x_i < 0) begin
        x_q[0] <= -x_i;
        y_q[0] <= -y_i;
        z_q[0] <= (y_i >= 0) ? TurnHalf : -TurnHalf;
      end else begin
        x_q[0] <= x_i;
        y_q[0] <= y_i;
        z_q[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_st
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else if (en_i) begin
        v_q[i+1] <= v_q[i];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zero_q[i+1] <= zero_q[i];
        if (y_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + atan_lut(i);
        end else begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - atan_lut(i);
        end
      end
    end
  end

  logic signed [67:0] pm_q;
  logic signed [AngW-1:0] za_q;
  logic zp_q, vp_q;
  logic signed [67:0] m_d;
  logic signed [AngW-1:0] zr_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= 1'b0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      vp_q <= v_q[N];
      valid_o <= vp_q;
    end
  end

  always_comb begin
    m_d = (pm_q + (68'sd1 <<< 37)) >>> 38;
    zr_d = (za_q + AngW'(32768)) >>> 16;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pm_q <= 68'(x_q[N]) * 68'(Kinv);
      za_q <= z_q[N];
      zp_q <= zero_q[N];
      if (zp_q) begin
        ang_o <= '0;
        spd_o <= '0;
      end else begin
        ang_o <= zr_d[15:0];
        if (m_d < 0) spd_o <= '0;
        else if (m_d > 68'sd65535) spd_o <= 16'hFFFF;
        else spd_o <= m_d[15:0];
      end
    end
  end
endmodule

FILE: design/swerve_wheel_kinematics.sv
// swerve drive inverse kinematics for four wheels at 135, 45, 315 and 225 degrees
// input stream s_axis: one chassis command word (speed, heading, yaw rate)
// output stream m_axis: one word with four steering angles and four speeds
// apb port: register 0 is arm_length in mm, reset value 300
// one command is taken every cycle while the pipeline is not stalled; the path runs through the
// rotation pipeline, gain multiply, vectoring pipeline and gain multiply
// every pipeline stage carries a valid bit
// when m_axis_tready is low with m_axis_tvalid high the whole pipeline holds; s_axis_tready drops
// only while the output register is full and stalled
// reset clears all valid bits and sets arm_length to 300
// angles are binary angles, 32768 = pi; speeds saturate at 65535 mm/s
// a zero wheel vector yields angle 0 and speed 0
module swerve_wheel_kinematics #(
  parameter int CORDIC_STAGES = swk_pkg::CordicStagesDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // linear_speed, heading, yaw_rate
  input  logic [47:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // angle_wheel0..3, speed_wheel0..3
  output logic [127:0] m_axis_tdata,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  import swk_pkg::*;

  logic [ArmW-1:0] arm_q;
  logic en;
  cmd_t cmd;
  logic rv;
  logic signed [VecW-1:0] vx, vy, r;
  logic signed [VecW-1:0] wx [4];
  logic signed [VecW-1:0] wy [4];
  logic vv [4];
  logic signed [15:0] ang [4];
  logic [15:0] spd [4];
  res_t res;

  assign pready = 1'b1;
  assign prdata = (paddr[1:0] == 2'b00) ? {20'd0, arm_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arm_q <= ArmReset;
    end else if (psel && penable && pwrite && paddr[1] == RegArm && paddr[0] == 1'b0) begin
      arm_q <= pwdata[ArmW-1:0];
    end
  end

  assign en = m_axis_tready || !m_axis_tvalid;
  assign s_axis_tready = en;
  assign cmd = cmd_t'({s_axis_tdata[15:0], s_axis_tdata[31:16], s_axis_tdata[47:32]});

  swk_rot #(.Stages(CORDIC_STAGES)) u_rot (
    .clk_i, .rst_ni, .en_i(en), .valid_i(s_axis_tvalid), .cmd_i(cmd), .arm_i(arm_q),
    .valid_o(rv), .vx_o(vx), .vy_o(vy), .r_o(r)
  );

  always_comb begin
    wx[0] = vx + r; wy[0] = vy - r;
    wx[1] = vx - r; wy[1] = vy - r;
    wx[2] = vx - r; wy[2] = vy + r;
    wx[3] = vx + r; wy[3] = vy + r;
  end

  for (genvar k = 0; k < 4; k++) begin : g_whl
    swk_vec #(.Stages(CORDIC_STAGES)) u_vec (
      .clk_i, .rst_ni, .en_i(en), .valid_i(rv), .x_i(wx[k]), .y_i(wy[k]),
      .valid_o(vv[k]), .ang_o(ang[k]), .spd_o(spd[k])
    );
  end

  always_comb begin
    res.angle_wheel0 = ang[0]; res.angle_wheel1 = ang[1];
    res.angle_wheel2 = ang[2]; res.angle_wheel3 = ang[3];
    res.speed_wheel0 = spd[0]; res.speed_wheel1 = spd[1];
    res.speed_wheel2 = spd[2]; res.speed_wheel3 = spd[3];
  end

  assign m_axis_tvalid = vv[0];
  assign m_axis_tdata = res;
endmodule

FILE: design/swk_chk.sv
module swk_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [127:0] m_axis_tdata,
  input logic pready
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word dropped under stall");
  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready) else $error("input blocked while output empty");
  a_prdy: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");
endmodule

bind swerve_wheel_kinematics swk_chk u_chk (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid, .m_axis_tready,
  .m_axis_tdata, .pready
);
